[rtl/core/assert_macros.svh]
// Assertion macros shared by the converter RTL.
// No dependencies; pulled in by each file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/core/itp_pkg.sv]
// Shared types, constants and character helpers for the infix-to-postfix converter.
// No dependencies; used by the controller, the datapath and the top level.
package itp_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_POW   = 8'h5E; // '^'
	localparam logic [7:0] CH_MUL   = 8'h2A; // '*'
	localparam logic [7:0] CH_DIV   = 8'h2F; // '/'
	localparam logic [7:0] CH_ADD   = 8'h2B; // '+'
	localparam logic [7:0] CH_SUB   = 8'h2D; // '-'
	localparam logic [7:0] CH_OPEN  = 8'h28; // '('
	localparam logic [7:0] CH_CLOSE = 8'h29; // ')'

	localparam logic signed [2:0] PREC_POW  = 3'sd3;
	localparam logic signed [2:0] PREC_MUL  = 3'sd2;
	localparam logic signed [2:0] PREC_ADD  = 3'sd1;
	localparam logic signed [2:0] PREC_NONE = -3'sd1;

	typedef enum logic [1:0] {
		CLS_OPERAND,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OTHER
	} sym_class_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;       // take the accepted item
		logic push;       // push current symbol (dropped when full)
		logic pop;        // remove top entry
		logic emit;       // place a character into the hold register
		logic emit_final; // send a character straight out as the item's last result
		logic src_cur;    // emitted character is the current symbol, else the top entry
		logic finish;     // send the held character, or an empty result, as the last result
		logic clear;      // end of expression: empty stack and overflow flag
	} itp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		sym_class_t sym_class;
		logic       last;
		logic       count_zero;
		logic       count_one;
		logic       top_open;
		logic       prec_le;
		logic       out_free;
	} itp_sts_t;

	function automatic logic signed [2:0] prec_of(input logic [7:0] c);
		logic signed [2:0] p;
		unique case (c)
			CH_POW:         p = PREC_POW;
			CH_MUL, CH_DIV: p = PREC_MUL;
			CH_ADD, CH_SUB: p = PREC_ADD;
			default:        p = PREC_NONE;
		endcase
		return p;
	endfunction

	function automatic sym_class_t class_of(input logic [7:0] c);
		sym_class_t k;
		if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h61 && c <= 8'h7A)) begin
			k = CLS_OPERAND;
		end else if (c == CH_OPEN) begin
			k = CLS_OPEN;
		end else if (c == CH_CLOSE) begin
			k = CLS_CLOSE;
		end else begin
			k = CLS_OTHER;
		end
		return k;
	endfunction

endpackage

[rtl/core/infix_to_postfix_converter.sv]
// Top level of the infix-to-postfix (shunting-yard) converter.
// Depends on itp_pkg, itp_ctrl and itp_dpath.
//
//  Channel  | Dir | Payload                                   | Handshake
//  ---------+-----+-------------------------------------------+--------------------------
//  s_axis   | in  | tdata: symbol; tlast: expr_last            | tvalid & tready
//  m_axis   | out | tdata: out_char; tlast: run_last;          | tvalid & tready
//           |     | tuser: has_char, expr_end, overflow        |
//
// An item is taken in S_IDLE and classified in S_CLASS. An operand is emitted from S_CLASS;
// an operator or closing bracket then pops operators from the stack one at a time, since
// the single stack read port delivers one character per cycle while the output register
// is free. At an expression end, S_FLUSH emits each remaining operator and then closes
// the run. The output register waits on m_axis_tready; while it is full and not taken,
// work stops and s_axis_tready stays low until the current item is done. Reset clears the
// stack count, the overflow flag and all valid flags; stack entries need no clearing.
module infix_to_postfix_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] symbol
	input  logic       s_axis_tlast,  // expr_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_char
	output logic       m_axis_tlast,  // run_last
	output logic [2:0] m_axis_tuser   // [0] has_char, [1] expr_end, [2] overflow
);
	import itp_pkg::*;

	itp_cmd_t cmd;
	itp_sts_t sts;

	logic has_char;
	logic expr_end;
	logic overflow;

	// Sequence each item: classify, pop while the rule allows, push, flush at the end.
	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the operator stack and the result registers.
	itp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_symbol    (s_axis_tdata),
		.in_last      (s_axis_tlast),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_char     (m_axis_tdata),
		.out_has_char (has_char),
		.out_run_last (m_axis_tlast),
		.out_expr_end (expr_end),
		.out_overflow (overflow)
	);

	// Pack the flags, lowest field first.
	assign m_axis_tuser = {overflow, expr_end, has_char};

endmodule

[rtl/core/itp_ctrl.sv]
// Sequencing state machine of the infix-to-postfix converter.
// Depends on itp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  itp_pkg::itp_sts_t sts,
	output itp_pkg::itp_cmd_t cmd
);
	import itp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_CLOSE,
		S_OTHER,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				if (sts.out_free) begin
					unique case (sts.sym_class)
						CLS_OPERAND: begin
							cmd.src_cur = 1'b1;
							if (!sts.last || sts.count_zero) begin
								cmd.emit_final = 1'b1;
								cmd.clear = sts.last;
								state_d = S_IDLE;
							end else begin
								cmd.emit = 1'b1;
								state_d = S_FLUSH;
							end
						end
						CLS_OPEN: begin
							cmd.push = 1'b1;
							if (sts.last) begin
								state_d = S_FLUSH;
							end else begin
								cmd.finish = 1'b1;
								state_d = S_IDLE;
							end
						end
						CLS_CLOSE: begin
							if (sts.count_zero) begin
								cmd.finish = 1'b1;
								cmd.clear = sts.last;
								state_d = S_IDLE;
							end else begin
								state_d = S_CLOSE;
							end
						end
						CLS_OTHER: begin
							state_d = S_OTHER;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_CLOSE: begin
				if (sts.out_free) begin
					if (!sts.count_zero && !sts.top_open) begin
						cmd.emit = 1'b1;
						cmd.pop = 1'b1;
					end else begin
						// drop the matching bracket, if any
						cmd.pop = !sts.count_zero;
						if (sts.last && !sts.count_zero && !sts.count_one) begin
							state_d = S_FLUSH;
						end else begin
							cmd.finish = 1'b1;
							cmd.clear = sts.last;
							state_d = S_IDLE;
						end
					end
				end
			end
			S_OTHER: begin
				if (sts.out_free) begin
					if (!sts.count_zero && sts.prec_le) begin
						cmd.emit = 1'b1;
						cmd.pop = 1'b1;
					end else begin
						cmd.push = 1'b1;
						cmd.src_cur = 1'b1;
						if (sts.last) begin
							state_d = S_FLUSH;
						end else begin
							cmd.finish = 1'b1;
							state_d = S_IDLE;
						end
					end
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					if (!sts.count_zero) begin
						cmd.emit = 1'b1;
						cmd.pop = 1'b1;
					end else begin
						cmd.finish = 1'b1;
						cmd.clear = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEVER(a_pop_empty, clk, arst_n, cmd.pop && sts.count_zero, "pop on empty stack")
	`ASSERT_NEVER(a_push_pop, clk, arst_n, cmd.push && cmd.pop, "push and pop together")
	`ASSERT_PROP(a_load_class, clk, arst_n, cmd.load |=> (state_q == S_CLASS), "item not classified")

endmodule

[rtl/core/itp_dpath.sv]
// Operator stack, hold register and output register of the converter.
// Depends on itp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itp_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_symbol,
	input  logic              in_last,
	input  itp_pkg::itp_cmd_t cmd,
	output itp_pkg::itp_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_char,
	output logic              out_has_char,
	output logic              out_run_last,
	output logic              out_expr_end,
	output logic              out_overflow
);
	import itp_pkg::*;

	logic [7:0]       stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic [7:0]       cur_q;
	logic             last_q;
	logic [7:0]       hold_char_q;
	logic             hold_valid_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_has_q;
	logic             out_rl_q;
	logic             out_ee_q;
	logic             out_ovf_q;

	logic [IDX_W-1:0] top_idx;
	logic [7:0]       top_char;
	logic             full;
	logic             ovf_now;
	logic             out_wr;
	logic [7:0]       src_char;

	assign top_idx  = count_q[IDX_W-1:0] - IDX_W'(1);
	assign top_char = stack_q[top_idx];
	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign ovf_now  = overflow_q | (cmd.push & full);
	assign src_char = cmd.src_cur ? cur_q : top_char;
	assign out_wr   = (cmd.emit & hold_valid_q) | cmd.emit_final | cmd.finish;

	always_comb begin
		sts.sym_class  = class_of(cur_q);
		sts.last       = last_q;
		sts.count_zero = (count_q == '0);
		sts.count_one  = (count_q == CNT_W'(1));
		sts.top_open   = (top_char == CH_OPEN);
		sts.prec_le    = (prec_of(cur_q) <= prec_of(top_char));
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= in_symbol;
			last_q <= in_last;
		end
		if (cmd.push && !full) begin
			stack_q[count_q[IDX_W-1:0]] <= cur_q;
		end
		if (cmd.emit) begin
			hold_char_q <= src_char;
		end
		if (out_wr) begin
			out_ovf_q <= ovf_now;
			if (cmd.emit_final) begin
				out_char_q <= src_char;
				out_has_q <= 1'b1;
				out_rl_q <= 1'b1;
				out_ee_q <= last_q;
			end else if (cmd.finish) begin
				out_char_q <= hold_valid_q ? hold_char_q : 8'h00;
				out_has_q <= hold_valid_q;
				out_rl_q <= 1'b1;
				out_ee_q <= last_q;
			end else begin
				out_char_q <= hold_char_q;
				out_has_q <= 1'b1;
				out_rl_q <= 1'b0;
				out_ee_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			overflow_q <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				overflow_q <= 1'b0;
			end else begin
				if (cmd.push && !full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cmd.pop) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (cmd.push && full) begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end else if (cmd.emit) begin
				hold_valid_q <= 1'b1;
			end
			if (out_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_has_char = out_has_q;
	assign out_run_last = out_rl_q;
	assign out_expr_end = out_ee_q;
	assign out_overflow = out_ovf_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(STACK_DEPTH), "stack count beyond depth")
	`ASSERT_NEVER(a_out_busy, clk, arst_n, out_wr && out_valid_q && !out_ready, "result overwrites waiting result")
	`ASSERT_PROP(a_final_clear, clk, arst_n, (cmd.finish || cmd.emit_final) |=> !hold_valid_q, "hold left full after final result")

endmodule
